FILE: rtl/barycentric_weights_2d_defines.svh
// assertion macros for the barycentric weights block
`ifndef BARYCENTRIC_WEIGHTS_2D_DEFINES_SVH
`define BARYCENTRIC_WEIGHTS_2D_DEFINES_SVH

// property checked every clock, skipped while reset is high
`define BWT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bwt assertion failed");

// property checked every clock, reset included
`define BWT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bwt assertion failed");

`endif

FILE: rtl/bwt_pkg.sv
// shared constants and types for the barycentric weights block
package bwt_pkg;

   localparam int COORD_BITS_DEF       = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;
   localparam int WEIGHT_BITS          = 32;
   localparam int LANES                = 3;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [LANES-1:0] neg;
   } ctl_type;

endpackage

FILE: rtl/bwt_front.sv
// edge differences, cross products, magnitudes and signs ahead of the divider chain
module bwt_front #(
   parameter int COORD_BITS       = bwt_pkg::COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = bwt_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int NB               = 2 * COORD_BITS + 4 + WEIGHT_FRAC_BITS,
   parameter int DB               = 2 * COORD_BITS + 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [COORD_BITS-1:0]                 px,
   input  logic [COORD_BITS-1:0]                 py,
   input  logic [COORD_BITS-1:0]                 ax,
   input  logic [COORD_BITS-1:0]                 ay,
   input  logic [COORD_BITS-1:0]                 bx,
   input  logic [COORD_BITS-1:0]                 by,
   input  logic [COORD_BITS-1:0]                 cx,
   input  logic [COORD_BITS-1:0]                 cy,
   output bwt_pkg::ctl_type                      ctl,
   output logic [bwt_pkg::LANES-1:0][NB-1:0]     num,
   output logic [DB-1:0]                         den
);

   localparam int C = COORD_BITS;
   localparam int P = 2 * C + 2;
   localparam int U = 2 * C + 3;
   localparam int S = 2 * C + 4;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [C:0]          abx_ff, acx_ff, pax_ff, aby_ff, acy_ff, pay_ff;
   logic [C:0]          abx_in, acx_in, pax_in, aby_in, acy_in, pay_in;
   logic signed [P-1:0] p_ff [6];
   logic signed [P-1:0] p_in [6];
   logic [U-1:0]        u3_ff, v3v_ff, w3_ff, u3_in, v3v_in, w3_in;
   logic [U-1:0]        u4_ff, v4v_ff, w4_ff;
   logic [S-1:0]        s4_ff, s4_in;
   logic [S-1:0]        mag_s, mag_u, mag_v;
   logic [U-1:0]        mag_w;
   logic [bwt_pkg::LANES-1:0][NB-1:0] num_ff, num_in;
   logic [DB-1:0]       den_ff, den_in;
   logic                degen_ff, degen_in;
   logic [bwt_pkg::LANES-1:0] neg_ff, neg_in;

   always_comb begin
      abx_in = {bx[C-1], bx} - {ax[C-1], ax};
      acx_in = {cx[C-1], cx} - {ax[C-1], ax};
      pax_in = {ax[C-1], ax} - {px[C-1], px};
      aby_in = {by[C-1], by} - {ay[C-1], ay};
      acy_in = {cy[C-1], cy} - {ay[C-1], ay};
      pay_in = {ay[C-1], ay} - {py[C-1], py};
   end

   always_comb begin
      p_in[0] = $signed(acx_ff) * $signed(pay_ff);
      p_in[1] = $signed(pax_ff) * $signed(acy_ff);
      p_in[2] = $signed(pax_ff) * $signed(aby_ff);
      p_in[3] = $signed(abx_ff) * $signed(pay_ff);
      p_in[4] = $signed(abx_ff) * $signed(acy_ff);
      p_in[5] = $signed(acx_ff) * $signed(aby_ff);
   end

   always_comb begin
      u3_in  = {p_ff[0][P-1], p_ff[0]} - {p_ff[1][P-1], p_ff[1]};
      v3v_in = {p_ff[2][P-1], p_ff[2]} - {p_ff[3][P-1], p_ff[3]};
      w3_in  = {p_ff[4][P-1], p_ff[4]} - {p_ff[5][P-1], p_ff[5]};
      s4_in  = {u3_ff[U-1], u3_ff} + {v3v_ff[U-1], v3v_ff};
   end

   always_comb begin
      mag_s = s4_ff[S-1] ? (~s4_ff + S'(1)) : s4_ff;
      mag_u = {1'b0, u4_ff[U-1] ? (~u4_ff + U'(1)) : u4_ff};
      mag_v = {1'b0, v4v_ff[U-1] ? (~v4v_ff + U'(1)) : v4v_ff};
      mag_w = w4_ff[U-1] ? (~w4_ff + U'(1)) : w4_ff;
      num_in[0] = {mag_s, {WEIGHT_FRAC_BITS{1'b0}}};
      num_in[1] = {mag_u, {WEIGHT_FRAC_BITS{1'b0}}};
      num_in[2] = {mag_v, {WEIGHT_FRAC_BITS{1'b0}}};
      den_in    = mag_w;
      degen_in  = (w4_ff == '0);
      neg_in[0] = s4_ff[S-1] ^ w4_ff[U-1];
      neg_in[1] = u4_ff[U-1] ^ w4_ff[U-1];
      neg_in[2] = v4v_ff[U-1] ^ w4_ff[U-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         abx_ff   <= abx_in;
         acx_ff   <= acx_in;
         pax_ff   <= pax_in;
         aby_ff   <= aby_in;
         acy_ff   <= acy_in;
         pay_ff   <= pay_in;
         p_ff     <= p_in;
         u3_ff    <= u3_in;
         v3v_ff   <= v3v_in;
         w3_ff    <= w3_in;
         s4_ff    <= s4_in;
         u4_ff    <= u3_ff;
         v4v_ff   <= v3v_ff;
         w4_ff    <= w3_ff;
         num_ff   <= num_in;
         den_ff   <= den_in;
         degen_ff <= degen_in;
         neg_ff   <= neg_in;
      end
   end

   assign ctl.valid = v5_ff;
   assign ctl.degen = degen_ff;
   assign ctl.neg   = neg_ff;
   assign num       = num_ff;
   assign den       = den_ff;

endmodule

FILE: rtl/bwt_div_cell.sv
// one restoring division step for three dividends sharing one divisor
module bwt_div_cell #(
   parameter int NB = 2 * bwt_pkg::COORD_BITS_DEF + 4 + bwt_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int DB = 2 * bwt_pkg::COORD_BITS_DEF + 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  bwt_pkg::ctl_type                  ctl_i,
   input  logic [bwt_pkg::LANES-1:0][DB-1:0] rem_i,
   input  logic [bwt_pkg::LANES-1:0][NB-1:0] nq_i,
   input  logic [DB-1:0]                     den_i,
   output bwt_pkg::ctl_type                  ctl_o,
   output logic [bwt_pkg::LANES-1:0][DB-1:0] rem_o,
   output logic [bwt_pkg::LANES-1:0][NB-1:0] nq_o,
   output logic [DB-1:0]                     den_o
);

   bwt_pkg::ctl_type                  ctl_ff;
   logic [bwt_pkg::LANES-1:0][DB-1:0] rem_ff, rem_in;
   logic [bwt_pkg::LANES-1:0][NB-1:0] nq_ff, nq_in;
   logic [DB-1:0]                     den_ff;
   logic [DB:0]                       part [bwt_pkg::LANES];
   logic [DB:0]                       diff [bwt_pkg::LANES];
   logic                              ge   [bwt_pkg::LANES];

   always_comb begin
      for (int l = 0; l < bwt_pkg::LANES; l++) begin
         part[l]   = {rem_i[l], nq_i[l][NB-1]};
         diff[l]   = part[l] - {1'b0, den_i};
         ge[l]     = (part[l] >= {1'b0, den_i});
         rem_in[l] = ge[l] ? diff[l][DB-1:0] : part[l][DB-1:0];
         nq_in[l]  = {nq_i[l][NB-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (en) begin
         ctl_ff.degen <= ctl_i.degen;
         ctl_ff.neg   <= ctl_i.neg;
         rem_ff       <= rem_in;
         nq_ff        <= nq_in;
         den_ff       <= den_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign nq_o  = nq_ff;
   assign den_o = den_ff;

endmodule

FILE: rtl/barycentric_weights_2d.sv
// top level: barycentric weights of a point in a 2D triangle
//
// request channel: req_valid/req_ready with point and three vertices,
// signed fixed point, one transfer per item
// response channel: rsp_valid/rsp_ready with weights a, b, c in signed
// fixed point (WEIGHT_FRAC_BITS fraction bits) and a degenerate flag
// throughput: one item per cycle, sustained while responses are not stalled
// the path from request to response runs through the five front stages,
// one divider cell per quotient bit and the output register
// a stalled response stops the whole pipeline and drops req_ready, so
// nothing is lost; req_ready is high whenever the output register is
// empty or being drained
// reset clears all valid bits together; no clearing pass
// a zero denominator gives weights -1, 1, 1 with degenerate set
module barycentric_weights_2d #(
   parameter int COORD_BITS       = bwt_pkg::COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = bwt_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_BITS-1:0]   req_point_x,
   input  logic signed [COORD_BITS-1:0]   req_point_y,
   input  logic signed [COORD_BITS-1:0]   req_vert_a_x,
   input  logic signed [COORD_BITS-1:0]   req_vert_a_y,
   input  logic signed [COORD_BITS-1:0]   req_vert_b_x,
   input  logic signed [COORD_BITS-1:0]   req_vert_b_y,
   input  logic signed [COORD_BITS-1:0]   req_vert_c_x,
   input  logic signed [COORD_BITS-1:0]   req_vert_c_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [bwt_pkg::WEIGHT_BITS-1:0] rsp_weight_a,
   output logic signed [bwt_pkg::WEIGHT_BITS-1:0] rsp_weight_b,
   output logic signed [bwt_pkg::WEIGHT_BITS-1:0] rsp_weight_c,
   output logic                           rsp_degenerate
);

   localparam int WB = bwt_pkg::WEIGHT_BITS;
   localparam int L  = bwt_pkg::LANES;
   localparam int NB = 2 * COORD_BITS + 4 + WEIGHT_FRAC_BITS;
   localparam int DB = 2 * COORD_BITS + 3;
   localparam int SW = (NB + 2 > WB + 2) ? NB + 2 : WB + 2;
   localparam logic [WB-1:0] ONE_W  = WB'(1) << WEIGHT_FRAC_BITS;
   localparam logic [SW-1:0] ONE_S  = SW'(1) << WEIGHT_FRAC_BITS;
   localparam logic [WB-1:0] MAX_W  = {1'b0, {(WB-1){1'b1}}};
   localparam logic [WB-1:0] MIN_W  = {1'b1, {(WB-1){1'b0}}};

   function automatic logic [WB-1:0] sat_w(input logic [SW-1:0] x);
      logic [SW-WB:0] top;
      top = x[SW-1:WB-1];
      if (!x[SW-1] && (top != '0)) begin
         return MAX_W;
      end else if (x[SW-1] && (top != '1)) begin
         return MIN_W;
      end else begin
         return x[WB-1:0];
      end
   endfunction

   logic en;

   bwt_pkg::ctl_type            ctl_c [NB+1];
   logic [L-1:0][DB-1:0]        rem_c [NB+1];
   logic [L-1:0][NB-1:0]        nq_c  [NB+1];
   logic [DB-1:0]               den_c [NB+1];

   logic [SW-1:0]               qe    [L];
   logic [SW-1:0]               sq    [L];
   logic [SW-1:0]               wa_full;

   logic                        rsp_valid_ff;
   logic [WB-1:0]               wa_ff, wb_ff, wc_ff, wa_in, wb_in, wc_in;
   logic                        degen_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   bwt_front #(
      .COORD_BITS      (COORD_BITS),
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
      .NB              (NB),
      .DB              (DB)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_valid(req_valid),
      .px      (req_point_x),
      .py      (req_point_y),
      .ax      (req_vert_a_x),
      .ay      (req_vert_a_y),
      .bx      (req_vert_b_x),
      .by      (req_vert_b_y),
      .cx      (req_vert_c_x),
      .cy      (req_vert_c_y),
      .ctl     (ctl_c[0]),
      .num     (nq_c[0]),
      .den     (den_c[0])
   );

   assign rem_c[0] = '0;

   for (genvar i = 0; i < NB; i++) begin : g_cell
      bwt_div_cell #(
         .NB(NB),
         .DB(DB)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .en   (en),
         .ctl_i(ctl_c[i]),
         .rem_i(rem_c[i]),
         .nq_i (nq_c[i]),
         .den_i(den_c[i]),
         .ctl_o(ctl_c[i+1]),
         .rem_o(rem_c[i+1]),
         .nq_o (nq_c[i+1]),
         .den_o(den_c[i+1])
      );
   end

   always_comb begin
      for (int l = 0; l < L; l++) begin
         qe[l] = {{(SW-NB){1'b0}}, nq_c[NB][l]};
         sq[l] = ctl_c[NB].neg[l] ? (~qe[l] + SW'(1)) : qe[l];
      end
      wa_full = ONE_S - sq[0];
      if (ctl_c[NB].degen) begin
         wa_in = ~ONE_W + WB'(1);
         wb_in = ONE_W;
         wc_in = ONE_W;
      end else begin
         wa_in = sat_w(wa_full);
         wb_in = sat_w(sq[1]);
         wc_in = sat_w(sq[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_c[NB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wa_ff    <= wa_in;
         wb_ff    <= wb_in;
         wc_ff    <= wc_in;
         degen_ff <= ctl_c[NB].degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight_a   = wa_ff;
   assign rsp_weight_b   = wb_ff;
   assign rsp_weight_c   = wc_ff;
   assign rsp_degenerate = degen_ff;

endmodule

FILE: rtl/bwt_checker.sv
// port-level checks for the barycentric weights block, bound to the top level
`include "barycentric_weights_2d_defines.svh"

module bwt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bwt_pkg::WEIGHT_BITS-1:0] rsp_weight_a,
   input logic [bwt_pkg::WEIGHT_BITS-1:0] rsp_weight_b,
   input logic [bwt_pkg::WEIGHT_BITS-1:0] rsp_weight_c,
   input logic                            rsp_degenerate
);

   // a stalled response stays valid and keeps weight a
   `BWT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight_a))

   // no response right after reset
   `BWT_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid)

   // an empty output register never blocks requests
   `BWT_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // degenerate weights: b equals c and a is the negation of b
   `BWT_ASSERT(a_degen_weights, clock, reset, rsp_valid && rsp_degenerate |-> rsp_weight_b == rsp_weight_c && rsp_weight_a == (~rsp_weight_b + 1'b1))

endmodule

bind barycentric_weights_2d bwt_checker u_bwt_checker (.*);
